[rtl/core/assert_macros.svh]
// assertion macros shared by the player rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition that must hold at every clock edge outside reset
`define VPP_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("vpp assertion failed");

// antecedent at one edge implies consequent at the same edge
`define VPP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vpp assertion failed");

`else

`define VPP_ASSERT_ALWAYS(label, clk, rst, cond)
`define VPP_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

[rtl/core/vpp_pkg.sv]
// types, codes and constants of the four-voice pcm player
package vpp_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP1,
      ST_STEP2,
      ST_VOL,
      ST_RD,
      ST_MUL,
      ST_ACC,
      ST_OUT
   } state_type;

   // request kinds carried in tuser
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;
   localparam logic [1:0] REQ_LOAD  = 2'd3;

   // voice register codes
   localparam logic [3:0] REG_START_LO = 4'h0;
   localparam logic [3:0] REG_START_HI = 4'h2;
   localparam logic [3:0] REG_END_LO   = 4'h4;
   localparam logic [3:0] REG_END_HI   = 4'h6;
   localparam logic [3:0] REG_STEP     = 4'h8;
   localparam logic [3:0] REG_VOLUME   = 4'hA;
   localparam logic [3:0] REG_PLAY     = 4'hC;
   localparam logic [3:0] REG_STATUS   = 4'hE;

   // csr indexes
   localparam logic CSR_CHIP_CLOCK  = 1'b0;
   localparam logic CSR_OUTPUT_RATE = 1'b1;

   // result kinds
   localparam logic RSP_KIND_READ = 1'b0;
   localparam logic RSP_KIND_MIX  = 1'b1;

   // reset values and fixed constants
   localparam logic [25:0] CHIP_CLOCK_RESET  = 26'd3579545;
   localparam logic [17:0] OUTPUT_RATE_RESET = 18'd48000;
   localparam int          DEF_ROM_ADDR_BITS = 20;
   localparam logic [7:0]  STEP_DISABLED     = 8'hFF;
   localparam logic [8:0]  PRESCALE_BASE     = 9'h100;
   localparam logic [8:0]  VOLUME_BIAS       = 9'd10;
   localparam logic [19:0] END_MARGIN        = 20'h00020;

   // divider widths
   localparam int DIV_NUM_W = 32;
   localparam int DIV_DEN_W = 18;

   // request into the shared divider
   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

endpackage

[rtl/core/vpp_divider.sv]
// shared restoring divider, one quotient bit per cycle
module vpp_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  vpp_pkg::div_req_type             div_req,
   output logic                             div_done,
   output logic [vpp_pkg::DIV_NUM_W-1:0]    div_quo
);
   import vpp_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   // one shift-subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_NUM_W-1]};
      fits    = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = DIV_DEN_W'(trial - {1'b0, den_ff});
         end else begin
            rem_in = trial[DIV_DEN_W-1:0];
         end
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_done = done_ff;
   assign div_quo  = quo_ff;

endmodule

[rtl/core/vpp_sample_mem.sv]
// sample byte memory, one port, registered read
module vpp_sample_mem #(
   parameter int ADDR_BITS = vpp_pkg::DEF_ROM_ADDR_BITS
) (
   input  logic                 clock,
   input  logic                 mem_we,
   input  logic [ADDR_BITS-1:0] mem_addr,
   input  logic [7:0]           mem_wdata,
   output logic [7:0]           mem_rdata
);
   import vpp_pkg::*;

   logic [7:0] mem_ff [2**ADDR_BITS];
   logic [7:0] rdata_ff;

   // write on load; the read is registered every cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_addr] <= mem_wdata;
      end
      rdata_ff <= mem_ff[mem_addr];
   end

   assign mem_rdata = rdata_ff;

endmodule

[rtl/core/four_voice_pcm_sample_player.sv]
// Four-voice 8-bit PCM player. One beat is accepted at a time; req_tready is
// low while an item is in work. A register write of the step rate makes two
// 32-step passes through the shared divider, or none when the code is 255 or
// the output rate is zero; a volume write makes one pass. Other writes, reads
// and sample-byte loads finish in the accepting cycle. A sample tick runs the
// states ST_RD, ST_MUL and ST_ACC for each voice in turn (memory read,
// multiply, accumulate), then ST_OUT hands the mixed sample to the output
// register. A result waiting on rsp_ that is not being taken holds back every
// request beat, and a finished tick waits in its last state until the output
// register is free.
`include "assert_macros.svh"

module four_voice_pcm_sample_player #(
   parameter int ROM_ADDR_BITS = vpp_pkg::DEF_ROM_ADDR_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: reg_offset[5:0], reg_data[13:6], rom_address[33:14], rom_byte[41:34]
   input  logic [47:0] req_tdata,
   // tuser: req_type[1:0]
   input  logic [1:0]  req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: read_value[0], mix_sample[16:1]
   output logic [23:0] rsp_tdata,
   // tuser: result_kind[0]
   output logic        rsp_tuser,
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [25:0] csr_wdata
);
   import vpp_pkg::*;

   state_type state_ff, state_in;

   // configuration registers
   logic [25:0] clock_hz_ff;
   logic [17:0] rate_hz_ff;

   // voice state
   logic [19:0] start_ff   [4];
   logic [19:0] end_ff     [4];
   logic [31:0] step_ff    [4];
   logic [7:0]  vol_ff     [4];
   logic [3:0]  playing_ff;
   logic [31:0] pos_ff     [4];

   // sequencing and mixing
   logic [1:0]         v_ff;
   logic [1:0]         wv_ff;
   logic signed [15:0] prod_ff;
   logic signed [17:0] sum_ff;

   // result register
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff;
   logic        rsp_kind_ff;

   // request fields
   logic [1:0]  req_kind;
   logic [5:0]  in_offset;
   logic [7:0]  in_data;
   logic [19:0] in_rom_addr;
   logic [7:0]  in_rom_byte;
   logic [1:0]  in_v;
   logic [3:0]  in_reg;

   logic accept;
   logic out_free;
   logic step_div;
   logic vol_div;

   div_req_type       div_req;
   logic              div_done;
   logic [31:0]       div_quo;

   logic                     mem_we;
   logic [ROM_ADDR_BITS-1:0] mem_addr;
   logic [7:0]               mem_rdata;

   logic [31:0]        pos_next;
   logic [19:0]        end_less;
   logic [31:0]        limit;
   logic signed [7:0]  smp;
   logic signed [8:0]  volx;
   logic signed [16:0] prod_full;

   assign req_kind    = req_tuser;
   assign in_offset   = req_tdata[5:0];
   assign in_data     = req_tdata[13:6];
   assign in_rom_addr = req_tdata[33:14];
   assign in_rom_byte = req_tdata[41:34];
   assign in_v        = in_offset[5:4];
   assign in_reg      = in_offset[3:0];

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign accept   = req_tvalid && req_tready;
   assign step_div = (req_kind == REQ_WRITE) && (in_reg == REG_STEP) &&
                     (in_data != STEP_DISABLED) && (rate_hz_ff != '0);
   assign vol_div  = (req_kind == REQ_WRITE) && (in_reg == REG_VOLUME);

   // voice arithmetic for the current tick voice
   assign pos_next  = pos_ff[v_ff] + step_ff[v_ff];
   assign end_less  = end_ff[v_ff] - END_MARGIN;
   assign limit     = {4'h0, end_less, 8'h00};
   assign smp       = {~mem_rdata[7], mem_rdata[6:0]};
   assign volx      = {1'b0, vol_ff[v_ff]};
   assign prod_full = smp * volx;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (step_div) begin
                  state_in = ST_STEP1;
               end else if (vol_div) begin
                  state_in = ST_VOL;
               end else if (req_kind == REQ_TICK) begin
                  state_in = ST_RD;
               end
            end
         end
         ST_STEP1: begin
            if (div_done) begin
               state_in = ST_STEP2;
            end
         end
         ST_STEP2: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_VOL: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD:  state_in = ST_MUL;
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            state_in = (v_ff == 2'd3) ? ST_OUT : ST_RD;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: handshake, divider requests, memory port
   always_comb begin
      req_tready       = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = out_free;
            if (accept && step_div) begin
               div_req.start    = 1'b1;
               div_req.dividend = {6'h00, clock_hz_ff};
               div_req.divisor  = {9'h000, PRESCALE_BASE - {1'b0, in_data}};
            end else if (accept && vol_div) begin
               div_req.start    = 1'b1;
               div_req.dividend = {16'h0000, in_data, 8'h00};
               div_req.divisor  = {9'h000, {1'b0, in_data} + VOLUME_BIAS};
            end
         end
         ST_STEP1: begin
            if (div_done) begin
               div_req.start    = 1'b1;
               div_req.dividend = {div_quo[25:2], 8'h00};
               div_req.divisor  = rate_hz_ff;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      mem_we   = accept && (req_kind == REQ_LOAD);
      mem_addr = mem_we ? in_rom_addr[ROM_ADDR_BITS-1:0]
                        : pos_ff[v_ff][8 +: ROM_ADDR_BITS];
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= CHIP_CLOCK_RESET;
         rate_hz_ff  <= OUTPUT_RATE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHIP_CLOCK:  clock_hz_ff <= csr_wdata;
            CSR_OUTPUT_RATE: rate_hz_ff  <= csr_wdata[17:0];
            default:         clock_hz_ff <= clock_hz_ff;
         endcase
      end
   end

   // voice registers: writes, divider results, tick advance
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            start_ff[i] <= '0;
            end_ff[i]   <= '0;
            step_ff[i]  <= '0;
            vol_ff[i]   <= '0;
            pos_ff[i]   <= '0;
         end
         playing_ff <= '0;
      end else begin
         if (accept && (req_kind == REQ_WRITE)) begin
            case (in_reg)
               REG_START_LO: start_ff[in_v] <= {start_ff[in_v][19:12], in_data, 4'h0};
               REG_START_HI: start_ff[in_v] <= {in_data, start_ff[in_v][11:4], 4'h0};
               REG_END_LO:   end_ff[in_v]   <= {end_ff[in_v][19:12], in_data, 4'h0};
               REG_END_HI:   end_ff[in_v]   <= {in_data, end_ff[in_v][11:4], 4'h0};
               REG_STEP: begin
                  if (!step_div) begin
                     step_ff[in_v] <= '0;
                  end
               end
               REG_PLAY: begin
                  playing_ff[in_v] <= (in_data != 8'h00);
                  pos_ff[in_v]     <= {4'h0, start_ff[in_v], 8'h00};
               end
               default: playing_ff <= playing_ff;
            endcase
         end
         if ((state_ff == ST_STEP2) && div_done) begin
            step_ff[wv_ff] <= div_quo;
         end
         if ((state_ff == ST_VOL) && div_done) begin
            vol_ff[wv_ff] <= div_quo[7:0];
         end
         if ((state_ff == ST_MUL) && playing_ff[v_ff]) begin
            pos_ff[v_ff] <= pos_next;
            if (end_ff[v_ff] >= END_MARGIN) begin
               playing_ff[v_ff] <= (pos_next < limit);
            end
         end
      end
   end

   // tick voice counter
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (accept) begin
         v_ff <= '0;
      end else if (state_ff == ST_ACC && v_ff != 2'd3) begin
         v_ff <= v_ff + 2'd1;
      end
   end

   // written voice, product and running sum
   always_ff @(posedge clock) begin
      if (accept) begin
         wv_ff  <= in_v;
         sum_ff <= '0;
      end else if (state_ff == ST_ACC) begin
         sum_ff <= sum_ff + {{2{prod_ff[15]}}, prod_ff};
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= playing_ff[v_ff] ? prod_full[15:0] : 16'sh0000;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && (req_kind == REQ_READ)) begin
         rsp_valid_ff <= 1'b1;
      end else if ((state_ff == ST_OUT) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_kind == REQ_READ)) begin
         rsp_kind_ff <= RSP_KIND_READ;
         rsp_data_ff <= {23'h000000,
                         (in_reg == REG_STATUS) && playing_ff[in_v]};
      end else if ((state_ff == ST_OUT) && out_free) begin
         rsp_kind_ff <= RSP_KIND_MIX;
         rsp_data_ff <= {7'h00, sum_ff[17:2], 1'b0};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   vpp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   vpp_sample_mem #(
      .ADDR_BITS (ROM_ADDR_BITS)
   ) u_sample_mem (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (in_rom_byte),
      .mem_rdata (mem_rdata)
   );

   // divider finishes only while the sequencer waits for it
   `VPP_ASSERT_IMPLIES(a_div_done_state, clock, reset, div_done, (state_ff == ST_STEP1) || (state_ff == ST_STEP2) || (state_ff == ST_VOL))

   // the mix is handed over only after the last voice
   `VPP_ASSERT_IMPLIES(a_out_last_voice, clock, reset, state_ff == ST_OUT, v_ff == 2'd3)

   // a new mixed-sample beat comes from the output state
   `VPP_ASSERT_IMPLIES(a_mix_from_out, clock, reset, $rose(rsp_tvalid) && (rsp_tuser == RSP_KIND_MIX), $past(state_ff) == ST_OUT)

endmodule

[tb/vpp_result_checker.sv]
// result checker for the four-voice pcm player: tracks voice state and compares result beats
module vpp_result_checker #(
   parameter int ROM_BITS = vpp_pkg::DEF_ROM_ADDR_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [47:0]      req_tdata,
   input  logic [1:0]       req_tuser,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [23:0]      rsp_tdata,
   input  logic             rsp_tuser,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [25:0]      csr_wdata,
   output int               mismatches,
   output int               results_outstanding,
   // byte address each voice fetches on the next tick, and which playing voices' bytes are not loaded yet
   output logic [3:0][19:0] fetch_addr,
   output logic [3:0]       fetch_unloaded
);
   import vpp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ROM_MASK = (32'd1 << ROM_BITS) - 32'd1;

   typedef struct packed {
      logic        kind;
      logic        status;
      logic [15:0] sample;
   } player_result_type;

   // shadow of the player state
   logic [25:0]       clock_hz;
   logic [17:0]       rate_hz;
   logic [19:0]       start_addr [4];
   logic [19:0]       end_addr [4];
   logic [31:0]       step_inc [4];
   logic [31:0]       position [4];
   logic [7:0]        gain [4];
   logic [3:0]        playing;
   logic [7:0]        sample_bytes [int unsigned];
   player_result_type awaited_results [$];

   // fractional position increment for a pitch code
   function automatic logic [31:0] pitch_increment(input logic [7:0] d);
      longint unsigned base;
      if (d == STEP_DISABLED || rate_hz == 18'd0) return 32'd0;
      base = 64'(clock_hz) / (64'(PRESCALE_BASE) - 64'(d));
      base = base / 64'd4;
      return 32'((base << 8) / 64'(rate_hz));
   endfunction

   function automatic logic [7:0] voice_gain(input logic [7:0] d);
      return 8'((16'(d) * 16'd256) / (16'(d) + 16'(VOLUME_BIAS)));
   endfunction

   function automatic int unsigned fetch_key(input logic [31:0] pos);
      return (pos >> 8) & ROM_MASK;
   endfunction

   task automatic write_voice_reg(input logic [5:0] offset, input logic [7:0] d);
      int v;
      v = offset[5:4];
      case (offset[3:0])
         REG_START_LO: start_addr[v] = (start_addr[v] & 20'hff000) | (20'(d) << 4);
         REG_START_HI: start_addr[v] = (start_addr[v] & 20'h00ff0) | (20'(d) << 12);
         REG_END_LO:   end_addr[v] = (end_addr[v] & 20'hff000) | (20'(d) << 4);
         REG_END_HI:   end_addr[v] = (end_addr[v] & 20'h00ff0) | (20'(d) << 12);
         REG_STEP:     step_inc[v] = pitch_increment(d);
         REG_VOLUME:   gain[v] = voice_gain(d);
         REG_PLAY: begin
            playing[v] = (d != 8'd0);
            position[v] = {4'd0, start_addr[v], 8'd0};
         end
         default: ;
      endcase
   endtask

   // one tick: sum every playing voice, advance it and stop it at its end
   function automatic logic [15:0] mix_voices();
      int          sum;
      int          s;
      logic [31:0] limit;
      sum = 0;
      for (int v = 0; v < 4; v++) begin
         if (playing[v]) begin
            s = int'(sample_bytes[fetch_key(position[v])]) - 128;
            sum += s * int'(gain[v]);
            position[v] = position[v] + step_inc[v];
            if (end_addr[v] >= END_MARGIN) begin
               limit = {4'd0, end_addr[v] - END_MARGIN, 8'd0};
               playing[v] = (position[v] < limit);
            end
         end
      end
      return 16'(sum >>> 2);
   endfunction

   task automatic accept_request(input logic [1:0] kind, input logic [47:0] beat);
      player_result_type r;
      r = '0;
      case (kind)
         REQ_WRITE: write_voice_reg(beat[5:0], beat[13:6]);
         REQ_READ: begin
            r.kind = RSP_KIND_READ;
            r.status = (beat[3:0] == REG_STATUS) && playing[beat[5:4]];
            awaited_results.push_back(r);
         end
         REQ_TICK: begin
            r.kind = RSP_KIND_MIX;
            r.sample = mix_voices();
            awaited_results.push_back(r);
         end
         default: sample_bytes[32'(beat[33:14]) & ROM_MASK] = beat[41:34];
      endcase
   endtask

   task automatic check_result();
      player_result_type want;
      if (awaited_results.size() == 0) begin
         $error("result beat with nothing expected: kind %0d tdata %h", rsp_tuser, rsp_tdata);
         mismatches++;
      end else begin
         want = awaited_results.pop_front();
         if (rsp_tuser !== want.kind) begin
            $error("result_kind: expected %0d, actual %0d", want.kind, rsp_tuser);
            mismatches++;
         end
         if (rsp_tdata[0] !== want.status) begin
            $error("read_value: expected %0d, actual %0d", want.status, rsp_tdata[0]);
            mismatches++;
         end
         if (rsp_tdata[16:1] !== want.sample) begin
            $error("mix_sample: expected %0d, actual %0d",
                   $signed(want.sample), $signed(rsp_tdata[16:1]));
            mismatches++;
         end
      end
   endtask

   // sample every channel on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         clock_hz = CHIP_CLOCK_RESET;
         rate_hz = OUTPUT_RATE_RESET;
         for (int v = 0; v < 4; v++) begin
            start_addr[v] = '0;
            end_addr[v] = '0;
            step_inc[v] = '0;
            position[v] = '0;
            gain[v] = '0;
         end
         playing = '0;
         awaited_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CHIP_CLOCK:  clock_hz = csr_wdata;
               CSR_OUTPUT_RATE: rate_hz = csr_wdata[17:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) accept_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      results_outstanding = awaited_results.size();
      for (int v = 0; v < 4; v++) begin
         fetch_addr[v] = 20'(fetch_key(position[v]));
         fetch_unloaded[v] = playing[v] && !sample_bytes.exists(fetch_key(position[v]));
      end
   end

endmodule

[tb/tb_four_voice_pcm_sample_player.sv]
// testbench top for the four-voice pcm player: stimulus, idling and verdict
module tb_four_voice_pcm_sample_player;
   import vpp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         ITEM_TARGET    = 1850;
   localparam int         PHASE_COUNT    = 7;
   localparam int         SETTLE_CYCLES  = 100;
   localparam logic [3:0] REG_UNLISTED   = 4'hF;
   localparam int         READY_ALWAYS   = 0;
   localparam int         READY_RANDOM   = 1;
   localparam int         READY_SPARSE   = 2;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [47:0]      req_tdata;
   logic [1:0]       req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [23:0]      rsp_tdata;
   logic             rsp_tuser;
   logic             csr_we;
   logic             csr_index;
   logic [25:0]      csr_wdata;
   int               mismatches;
   int               results_outstanding;
   logic [3:0][19:0] fetch_addr;
   logic [3:0]       fetch_unloaded;

   int beats_sent;
   int burst_left;
   int ready_mode;
   int ready_left;

   four_voice_pcm_sample_player u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   vpp_result_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_tvalid          (req_tvalid),
      .req_tready          (req_tready),
      .req_tdata           (req_tdata),
      .req_tuser           (req_tuser),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_tdata           (rsp_tdata),
      .rsp_tuser           (rsp_tuser),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatches          (mismatches),
      .results_outstanding (results_outstanding),
      .fetch_addr          (fetch_addr),
      .fetch_unloaded      (fetch_unloaded)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #30_000_000;
      $display("four_voice_pcm_sample_player regression: fail");
      $finish;
   end

   // result side stalls in stretches of its own
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(READY_ALWAYS, READY_SPARSE);
         ready_left = $urandom_range(32, 256);
      end else begin
         ready_left--;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
         default:      rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // drop valid and idle for a span set by n
   task automatic hold_off(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // one request beat, held until accepted, then maybe a gap
   task automatic issue_beat(input logic [1:0] kind, input logic [5:0] offset,
                             input logic [7:0] d, input logic [19:0] addr,
                             input logic [7:0] sample);
      req_tuser <= kind;
      req_tdata <= {6'd0, sample, addr, d, offset};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      beats_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         hold_off($urandom_range(1, 12));
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 10);
      end
   endtask

   task automatic put_write(input logic [5:0] offset, input logic [7:0] d);
      issue_beat(REQ_WRITE, offset, d, 20'($urandom), 8'($urandom));
   endtask

   task automatic put_read(input logic [5:0] offset);
      issue_beat(REQ_READ, offset, 8'($urandom), 20'($urandom), 8'($urandom));
   endtask

   task automatic put_load(input logic [19:0] addr, input logic [7:0] sample);
      issue_beat(REQ_LOAD, 6'($urandom), 8'($urandom), addr, sample);
   endtask

   // load whatever the playing voices are about to fetch, then tick
   task automatic put_tick();
      int v;
      while (fetch_unloaded != 4'd0) begin
         v = 0;
         while (!fetch_unloaded[v]) v++;
         put_load(fetch_addr[v], 8'($urandom_range(0, 255)));
      end
      issue_beat(REQ_TICK, 6'($urandom), 8'($urandom), 20'($urandom), 8'($urandom));
   endtask

   // register writes only once the block has gone quiet
   task automatic set_rates(input logic [25:0] chip_hz, input logic [17:0] out_hz);
      hold_off(1);
      while (results_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_CHIP_CLOCK;
      csr_wdata <= chip_hz;
      @(negedge clock);
      csr_index <= CSR_OUTPUT_RATE;
      csr_wdata <= 26'(out_hz);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // full programming of one voice with random content
   task automatic program_voice();
      logic [1:0]  v;
      logic [19:0] start;
      logic [19:0] stop;
      int          pick;
      v = 2'($urandom);
      start = {20'($urandom)} & 20'hffff0;
      pick = $urandom_range(0, 99);
      if (pick < 70) stop = start + 20'($urandom_range(1, 64) * 16);
      else if (pick < 85) stop = 20'($urandom_range(0, 1) * 16);
      else stop = 20'($urandom) & 20'hffff0;
      put_write({v, REG_START_LO}, start[11:4]);
      put_write({v, REG_START_HI}, start[19:12]);
      put_write({v, REG_END_LO}, stop[11:4]);
      put_write({v, REG_END_HI}, stop[19:12]);
      put_write({v, REG_STEP}, 8'($urandom_range(0, 255)));
      put_write({v, REG_VOLUME}, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 4)) put_load(start + 20'($urandom_range(0, 15)),
                                             8'($urandom_range(0, 255)));
      put_write({v, REG_PLAY}, ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
   endtask

   task automatic random_step();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         program_voice();
      end else if (pick < 80) begin
         repeat ($urandom_range(1, 6)) begin
            put_tick();
            if ($urandom_range(0, 3) == 0) put_read({2'($urandom), REG_STATUS});
         end
      end else if (pick < 90) begin
         put_read(6'($urandom));
      end else if (pick < 95) begin
         put_write(6'($urandom), 8'($urandom));
      end else begin
         put_load(20'($urandom), 8'($urandom));
      end
   endtask

   task automatic apply_phase_rates(input int p);
      case (p)
         1: set_rates(26'd67108863, 18'd192000);
         2: set_rates(26'd1, 18'd1);
         3: set_rates(CHIP_CLOCK_RESET, 18'd0);
         4: set_rates(26'($urandom_range(1, 67108863)), 18'($urandom_range(1, 192000)));
         5: set_rates(26'd67108863, 18'd1);
         default: set_rates(26'd12000000, 18'd44100);
      endcase
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_WRITE;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_CHIP_CLOCK;
      csr_wdata = '0;
      beats_sent = 0;
      burst_left = 0;
      ready_mode = READY_ALWAYS;
      ready_left = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // status and unlisted offsets straight after reset
      put_read({2'd0, REG_STATUS});
      put_read({2'd3, REG_UNLISTED});
      put_write({2'd0, REG_UNLISTED}, 8'hFF);
      // voice 0: short run that reaches its end, full volume
      put_write({2'd0, REG_START_LO}, 8'h00);
      put_write({2'd0, REG_START_HI}, 8'h00);
      put_write({2'd0, REG_END_LO}, 8'h03);
      put_write({2'd0, REG_END_HI}, 8'h00);
      put_write({2'd0, REG_STEP}, 8'd254);
      put_write({2'd0, REG_VOLUME}, 8'hFF);
      put_write({2'd0, REG_PLAY}, 8'h01);
      // voice 1: top of memory, end below the margin, walks across the address wrap
      put_write({2'd1, REG_START_LO}, 8'hFF);
      put_write({2'd1, REG_START_HI}, 8'hFF);
      put_write({2'd1, REG_STEP}, 8'd254);
      put_write({2'd1, REG_VOLUME}, 8'h80);
      put_write({2'd1, REG_PLAY}, 8'hFF);
      // voice 2: disabled step and zero volume
      put_write({2'd2, REG_STEP}, STEP_DISABLED);
      put_write({2'd2, REG_VOLUME}, 8'h00);
      put_write({2'd2, REG_PLAY}, 8'h01);
      repeat (3) put_tick();
      put_read({2'd0, REG_STATUS});
      put_read({2'd1, REG_STATUS});
      put_write({2'd1, REG_PLAY}, 8'h00);
      put_read({2'd1, REG_STATUS});

      // random traffic under a run of rate settings
      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p > 0) apply_phase_rates(p);
         while (beats_sent < (p + 1) * ITEM_TARGET / PHASE_COUNT) random_step();
      end

      hold_off(1);
      while (results_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("four_voice_pcm_sample_player regression: pass");
      end else begin
         $display("four_voice_pcm_sample_player regression: fail");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/vpp_pkg.sv
rtl/core/vpp_divider.sv
rtl/core/vpp_sample_mem.sv
rtl/core/four_voice_pcm_sample_player.sv
tb/vpp_result_checker.sv
tb/tb_four_voice_pcm_sample_player.sv
